// ===== rtl/core/two_class_search_queue_rate_limited_top_assert.svh =====
// assertion macros for the two-class search queue
`ifndef TWO_CLASS_SEARCH_QUEUE_RATE_LIMITED_TOP_ASSERT_SVH
`define TWO_CLASS_SEARCH_QUEUE_RATE_LIMITED_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// property checked at every clock edge outside reset
`define TCSQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tcsq assertion failed");

// property checked at every clock edge, reset included
`define TCSQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("tcsq assertion failed");

`else

`define TCSQ_ASSERT(label, clk, rst, prop)
`define TCSQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/core/tcsq_pkg.sv =====
package tcsq_pkg;

   // request codes
   typedef enum logic [1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_CANCEL  = 2'd1,
      REQ_QUERY   = 2'd2,
      REQ_TICK    = 2'd3
   } req_code_type;

   // response status codes
   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_FULL        = 2'd1,
      STATUS_NOT_FOUND   = 2'd2,
      STATUS_NO_DISPATCH = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT_UP,
      ST_SHIFT_DOWN,
      ST_TICK_READ,
      ST_TICK_EVAL,
      ST_DONE
   } state_type;

   localparam int unsigned MS_PER_SECOND = 1000;
   localparam int unsigned INTERVAL_W    = 12;
   localparam int unsigned INTERVAL_MS_W = 22;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 12'd10;
   localparam logic [3:0] POSITION_MAX = 4'd15;

   typedef struct packed {
      req_code_type req_type;
      logic [15:0]  owner_id;
      logic [31:0]  search_ref;
      logic [63:0]  now_ms;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic        dispatched;
      logic [31:0] out_ref;
      logic [15:0] out_owner;
      logic [3:0]  position;
   } rsp_payload_type;

   // one queue slot
   typedef struct packed {
      logic [15:0] owner_id;
      logic [31:0] search_ref;
   } entry_type;

endpackage

// ===== rtl/core/two_class_search_queue_rate_limited_top.sv =====
// accept to response valid: enqueue, cancel and query scan the queue (not automatic or full enqueues),
// one entry scanned per cycle, then one entry moved per cycle (single read port)
// tick: reads the head, then dispatches it and shifts the queue when due and not empty
// one transaction in flight; the next request is taken once the response is loaded,
// and the response is loaded only while the response side keeps up
// reset: synchronous active high; queue empties, last dispatch time 0, interval 10 s
`include "two_class_search_queue_rate_limited_top_assert.svh"

module two_class_search_queue_rate_limited_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tcsq_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tcsq_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [tcsq_pkg::INTERVAL_W-1:0] csr_data
);

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   // queue storage
   tcsq_pkg::entry_type mem [QUEUE_DEPTH];
   tcsq_pkg::entry_type rd_data_ff;
   tcsq_pkg::entry_type mem_wdata;
   logic                mem_we;
   logic [IW-1:0]       mem_waddr;
   logic [IW-1:0]       mem_raddr;

   tcsq_pkg::state_type       state_ff, state_in;
   tcsq_pkg::req_payload_type req_ff, req_in;
   tcsq_pkg::rsp_payload_type res_ff, res_in;
   tcsq_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [63:0]               last_ms_ff, last_ms_in;
   logic [tcsq_pkg::INTERVAL_W-1:0]    interval_ff, interval_in;
   logic [tcsq_pkg::INTERVAL_MS_W-1:0] interval_ms_ff;
   logic [CW-1:0]             issue_ff, issue_in;
   logic                      cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]             cmp_idx_ff, cmp_idx_in;
   logic [CW-1:0]             target_ff, target_in;
   logic [CW-1:0]             shift_ff, shift_in;
   logic                      wr_vld_ff, wr_vld_in;
   logic [IW-1:0]             wr_addr_ff, wr_addr_in;
   logic                      due_ok_ff, due_ok_in;

   logic          accept;
   logic [15:0]   scan_key;
   logic          scan_hit;
   logic          scan_miss;
   logic          out_free;
   logic          due_hit;
   logic [CW-1:0] shift_dec;
   logic [CW-1:0] found_idx;
   logic [3:0]    hit_position;

   // shared conditions
   assign accept    = req_valid && req_ready;
   assign scan_key  = (req_ff.req_type == tcsq_pkg::REQ_ENQUEUE) ? 16'd0 : req_ff.owner_id;
   assign scan_hit  = cmp_vld_ff && (rd_data_ff.owner_id == scan_key);
   assign scan_miss = !cmp_vld_ff && (issue_ff == count_ff);
   assign found_idx = scan_hit ? CW'(cmp_idx_ff) : count_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign shift_dec = shift_ff - CW'(1);
   assign due_hit   = (last_ms_ff + 64'(interval_ms_ff)) < req_ff.now_ms;
   assign hit_position = (32'(cmp_idx_ff) > 32'(tcsq_pkg::POSITION_MAX)) ?
                         tcsq_pkg::POSITION_MAX : 4'(cmp_idx_ff);

   // ports
   assign req_ready = (state_ff == tcsq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcsq_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  tcsq_pkg::REQ_ENQUEUE: begin
                     if (count_ff == FULL_COUNT) begin
                        state_in = tcsq_pkg::ST_DONE;
                     end else if (req_data.owner_id == 16'd0) begin
                        state_in = tcsq_pkg::ST_SHIFT_UP;
                     end else begin
                        state_in = tcsq_pkg::ST_SCAN;
                     end
                  end
                  tcsq_pkg::REQ_CANCEL, tcsq_pkg::REQ_QUERY: begin
                     state_in = tcsq_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = tcsq_pkg::ST_TICK_READ;
                  end
               endcase
            end
         end
         tcsq_pkg::ST_SCAN: begin
            if (scan_hit || scan_miss) begin
               case (req_ff.req_type)
                  tcsq_pkg::REQ_ENQUEUE: state_in = tcsq_pkg::ST_SHIFT_UP;
                  tcsq_pkg::REQ_CANCEL: begin
                     state_in = scan_hit ? tcsq_pkg::ST_SHIFT_DOWN : tcsq_pkg::ST_DONE;
                  end
                  default: state_in = tcsq_pkg::ST_DONE;
               endcase
            end
         end
         tcsq_pkg::ST_SHIFT_UP: begin
            if (!(shift_ff > target_ff) && !wr_vld_ff) begin
               state_in = tcsq_pkg::ST_DONE;
            end
         end
         tcsq_pkg::ST_SHIFT_DOWN: begin
            if (!(shift_ff < count_ff) && !wr_vld_ff) begin
               state_in = tcsq_pkg::ST_DONE;
            end
         end
         tcsq_pkg::ST_TICK_READ: begin
            state_in = tcsq_pkg::ST_TICK_EVAL;
         end
         tcsq_pkg::ST_TICK_EVAL: begin
            if (due_ok_ff && (count_ff != '0)) begin
               state_in = tcsq_pkg::ST_SHIFT_DOWN;
            end else begin
               state_in = tcsq_pkg::ST_DONE;
            end
         end
         tcsq_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = tcsq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcsq_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      count_in     = count_ff;
      last_ms_in   = last_ms_ff;
      interval_in  = csr_valid ? csr_data : interval_ff;
      issue_in     = issue_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      target_in    = target_ff;
      shift_in     = shift_ff;
      wr_vld_in    = 1'b0;
      wr_addr_in   = wr_addr_ff;
      due_ok_in    = due_ok_ff;
      mem_we       = 1'b0;
      mem_waddr    = wr_addr_ff;
      mem_wdata    = rd_data_ff;
      mem_raddr    = '0;

      case (state_ff)
         tcsq_pkg::ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               issue_in = '0;
               res_in   = '{status: tcsq_pkg::STATUS_OK, dispatched: 1'b0,
                            out_ref: 32'd0, out_owner: 16'd0, position: 4'd0};
               if (req_data.req_type == tcsq_pkg::REQ_ENQUEUE) begin
                  if (count_ff == FULL_COUNT) begin
                     res_in.status = tcsq_pkg::STATUS_FULL;
                  end
                  // automatic requests go straight to the tail
                  target_in = count_ff;
                  shift_in  = count_ff;
               end
            end
         end
         tcsq_pkg::ST_SCAN: begin
            if (scan_hit || scan_miss) begin
               case (req_ff.req_type)
                  tcsq_pkg::REQ_ENQUEUE: begin
                     target_in = found_idx;
                     shift_in  = count_ff;
                  end
                  tcsq_pkg::REQ_CANCEL: begin
                     target_in = found_idx;
                     shift_in  = found_idx + CW'(1);
                     if (!scan_hit) begin
                        res_in.status = tcsq_pkg::STATUS_NOT_FOUND;
                     end
                  end
                  default: begin
                     if (scan_hit) begin
                        res_in.position = hit_position;
                     end else begin
                        res_in.status = tcsq_pkg::STATUS_NOT_FOUND;
                     end
                  end
               endcase
            end else if (issue_ff < count_ff) begin
               // issue one read per cycle, compare in the next cycle
               mem_raddr  = issue_ff[IW-1:0];
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[IW-1:0];
               issue_in   = issue_ff + CW'(1);
            end
         end
         tcsq_pkg::ST_SHIFT_UP: begin
            // move entries one slot toward the tail, top down
            if (wr_vld_ff) begin
               mem_we = 1'b1;
            end
            if (shift_ff > target_ff) begin
               mem_raddr  = shift_dec[IW-1:0];
               wr_vld_in  = 1'b1;
               wr_addr_in = shift_ff[IW-1:0];
               shift_in   = shift_dec;
            end else if (!wr_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = target_ff[IW-1:0];
               mem_wdata = '{owner_id: req_ff.owner_id, search_ref: req_ff.search_ref};
               count_in  = count_ff + CW'(1);
            end
         end
         tcsq_pkg::ST_SHIFT_DOWN: begin
            // close the gap, bottom up
            if (wr_vld_ff) begin
               mem_we = 1'b1;
            end
            if (shift_ff < count_ff) begin
               mem_raddr  = shift_ff[IW-1:0];
               wr_vld_in  = 1'b1;
               wr_addr_in = shift_dec[IW-1:0];
               shift_in   = shift_ff + CW'(1);
            end else if (!wr_vld_ff) begin
               count_in = count_ff - CW'(1);
            end
         end
         tcsq_pkg::ST_TICK_READ: begin
            mem_raddr = '0;
            due_ok_in = due_hit;
         end
         tcsq_pkg::ST_TICK_EVAL: begin
            if (due_ok_ff && (count_ff != '0)) begin
               res_in.dispatched = 1'b1;
               res_in.out_ref    = rd_data_ff.search_ref;
               res_in.out_owner  = rd_data_ff.owner_id;
               last_ms_in        = req_ff.now_ms;
               target_in         = '0;
               shift_in          = CW'(1);
            end else begin
               res_in.status = tcsq_pkg::STATUS_NO_DISPATCH;
            end
         end
         tcsq_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // queue memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tcsq_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         count_ff       <= '0;
         last_ms_ff     <= '0;
         interval_ff    <= tcsq_pkg::INTERVAL_RESET;
         interval_ms_ff <= tcsq_pkg::INTERVAL_MS_W'(tcsq_pkg::INTERVAL_RESET) *
                           tcsq_pkg::INTERVAL_MS_W'(tcsq_pkg::MS_PER_SECOND);
         cmp_vld_ff     <= 1'b0;
         wr_vld_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         count_ff       <= count_in;
         last_ms_ff     <= last_ms_in;
         interval_ff    <= interval_in;
         interval_ms_ff <= tcsq_pkg::INTERVAL_MS_W'(interval_ff) *
                           tcsq_pkg::INTERVAL_MS_W'(tcsq_pkg::MS_PER_SECOND);
         cmp_vld_ff     <= cmp_vld_in;
         wr_vld_ff      <= wr_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
      issue_ff   <= issue_in;
      cmp_idx_ff <= cmp_idx_in;
      target_ff  <= target_in;
      shift_ff   <= shift_in;
      wr_addr_ff <= wr_addr_in;
      due_ok_ff  <= due_ok_in;
   end

   // checks
   `TCSQ_ASSERT(a_count_bound, clock, reset, count_ff <= FULL_COUNT)
   `TCSQ_ASSERT(a_no_write_idle, clock, reset, (state_ff == tcsq_pkg::ST_IDLE) |-> !mem_we)
   `TCSQ_ASSERT(a_dispatch_ok, clock, reset,
                (rsp_valid_ff && rsp_ff.dispatched) |-> (rsp_ff.status == tcsq_pkg::STATUS_OK))
   `TCSQ_ASSERT(a_count_step, clock, reset,
                (!$past(reset) && !$stable(count_ff)) |->
                ((count_ff == $past(count_ff) + CW'(1)) ||
                 (count_ff == $past(count_ff) - CW'(1))))
   `TCSQ_ASSERT(a_last_on_tick, clock, reset,
                (!$past(reset) && !$stable(last_ms_ff)) |->
                ($past(state_ff) == tcsq_pkg::ST_TICK_EVAL))

endmodule
